>>> hw/rtl/windowed_average_min_max_tracker_assert.svh
// ----------------------------------------------------------------------------
// windowed average tracker assertion macros
// concurrent checks, compiled out when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef WINDOWED_AVERAGE_MIN_MAX_TRACKER_ASSERT_SVH
`define WINDOWED_AVERAGE_MIN_MAX_TRACKER_ASSERT_SVH
`ifndef SYNTH
// property holds at every edge out of reset
`define WAMA_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("wama assertion failed");
// antecedent implies consequent in the same cycle
`define WAMA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wama assertion failed");
// antecedent implies consequent in the next cycle
`define WAMA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wama assertion failed");
`else
`define WAMA_ASSERT(lbl, clk, rst_n, prop)
`define WAMA_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define WAMA_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> hw/rtl/wama_pkg.sv
// ----------------------------------------------------------------------------
// wama_pkg
// shared widths, constants and types of the windowed average tracker
// ----------------------------------------------------------------------------
package wama_pkg;

  localparam int SMP_W       = 10;
  localparam int MIN_W       = 11;
  localparam int WINDOW_DEF  = 16;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_FIELD_W = 3 * SMP_W + MIN_W;
  localparam int OUT_TDATA_W = 48;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

  localparam logic [MIN_W-1:0] MIN_NONE = 11'd1025;

  // item kinds carried on in_tuser
  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_CLEAR  = 1'b1;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

>>> hw/rtl/wama_ring.sv
// ----------------------------------------------------------------------------
// wama_ring
// sample ring memory, one write and one registered read port
// ----------------------------------------------------------------------------
module wama_ring #(
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4,
  parameter int DATA_W = 10
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> hw/rtl/wama_div.sv
// ----------------------------------------------------------------------------
// wama_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module wama_div #(
  parameter int SUM_W = 14,
  parameter int CNT_W = 5
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [SUM_W-1:0]    dividend,
  input  logic [CNT_W-1:0]    divisor,
  output logic [SUM_W-1:0]    quotient,
  output wama_pkg::div_stat_t stat
);
  import wama_pkg::*;

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic [SUM_W-1:0]  quo_r, quo_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]  dvs_r, dvs_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    diff;
  logic              fits;

  assign trial = {rem_r, quo_r[SUM_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign fits  = trial >= {1'b0, dvs_r};

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      step_nxt = STEP_W'(SUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt  = {quo_r[SUM_W-2:0], fits};
      rem_nxt  = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      step_nxt = step_r - 1'b1;
      if (step_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

>>> hw/rtl/windowed_average_min_max_tracker.sv
// flow: a clear or a disabled sample goes straight from ST_IDLE to ST_OUT, which registers
// the result once the output is free; an enabled sample passes ST_READ (ring memory read),
// then ST_DIV, where the bit-serial divider forms sum / count, and then ST_OUT.
// in_tready is low outside ST_IDLE, so no new item is taken until the last result is registered.
// reset: synchronous active-low rst_n clears statistics, enable and handshakes.
// ----------------------------------------------------------------------------
// windowed_average_min_max_tracker
// sample ring with running sum, truncated mean, running maximum and minimum
// ----------------------------------------------------------------------------
`include "windowed_average_min_max_tracker_assert.svh"

module windowed_average_min_max_tracker #(
  parameter int WINDOW = wama_pkg::WINDOW_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic                             cfg_wr_data,  // enable
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [wama_pkg::IN_TDATA_W-1:0]  in_tdata,     // sample
  input  logic [0:0]                       in_tuser,     // mode
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [wama_pkg::OUT_TDATA_W-1:0] out_tdata     // latest, average, maximum, minimum
);
  import wama_pkg::*;

  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SUM_W  = $clog2(((1 << SMP_W) - 1) * WINDOW + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_OUT  = 3'd3;

  logic [2:0]             state_r, state_nxt;
  logic                   enable_r, enable_nxt;
  logic [SLOT_W-1:0]      slot_r, slot_nxt;
  logic [CNT_W-1:0]       held_r, held_nxt;
  logic [SUM_W-1:0]       sum_r, sum_nxt;
  logic [SMP_W-1:0]       peak_high_r, peak_high_nxt;
  logic [MIN_W-1:0]       peak_low_r, peak_low_nxt;
  logic [SMP_W-1:0]       last_r, last_nxt;
  logic [SMP_W-1:0]       mean_r, mean_nxt;
  logic [SMP_W-1:0]       smp_r, smp_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic                   in_xfer;
  logic [SMP_W-1:0]       in_sample;
  logic                   in_mode;
  logic                   full;
  logic [SMP_W-1:0]       old_smp;
  logic                   div_start;
  logic [SUM_W-1:0]       div_quo;
  div_stat_t              div_stat;

  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign in_sample = in_tdata[SMP_W-1:0];
  assign in_mode   = in_tuser[0];
  assign full      = (held_r == CNT_W'(WINDOW));
  assign div_start = (state_r == ST_READ);

  wama_ring #(
    .DEPTH  (WINDOW),
    .ADDR_W (SLOT_W),
    .DATA_W (SMP_W)
  ) u_ring (
    .clk     (clk),
    .wr_en   (div_start),
    .wr_addr (slot_r),
    .wr_data (smp_r),
    .rd_en   (in_xfer),
    .rd_addr (slot_r),
    .rd_data (old_smp)
  );

  wama_div #(
    .SUM_W (SUM_W),
    .CNT_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_nxt),
    .divisor  (held_nxt),
    .quotient (div_quo),
    .stat     (div_stat)
  );

  always_comb begin
    state_nxt     = state_r;
    enable_nxt    = enable_r;
    slot_nxt      = slot_r;
    held_nxt      = held_r;
    sum_nxt       = sum_r;
    peak_high_nxt = peak_high_r;
    peak_low_nxt  = peak_low_r;
    last_nxt      = last_r;
    mean_nxt      = mean_r;
    smp_nxt       = smp_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (cfg_wr_en) begin
      enable_nxt = cfg_wr_data;
    end
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          if (in_mode == MODE_CLEAR) begin
            enable_nxt    = 1'b0;
            slot_nxt      = '0;
            held_nxt      = '0;
            sum_nxt       = '0;
            peak_high_nxt = '0;
            peak_low_nxt  = MIN_NONE;
            last_nxt      = '0;
            mean_nxt      = '0;
            state_nxt     = ST_OUT;
          end else if (enable_r) begin
            last_nxt = in_sample;
            smp_nxt  = in_sample;
            if (in_sample > peak_high_r) begin
              peak_high_nxt = in_sample;
            end
            if ({1'b0, in_sample} < peak_low_r) begin
              peak_low_nxt = {1'b0, in_sample};
            end
            // oldest sample of this slot is read on the transfer edge
            state_nxt = ST_READ;
          end else begin
            state_nxt = ST_OUT;
          end
        end
      end
      ST_READ: begin
        if (full) begin
          sum_nxt = sum_r - SUM_W'(old_smp) + SUM_W'(smp_r);
        end else begin
          sum_nxt  = sum_r + SUM_W'(smp_r);
          held_nxt = held_r + 1'b1;
        end
        slot_nxt  = (slot_r == SLOT_W'(WINDOW - 1)) ? '0 : slot_r + 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_stat.done) begin
          mean_nxt  = div_quo[SMP_W-1:0];
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {{OUT_PAD_W{1'b0}}, peak_low_r, peak_high_r, mean_r, last_r};
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    smp_r      <= smp_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      enable_r    <= 1'b0;
      slot_r      <= '0;
      held_r      <= '0;
      sum_r       <= '0;
      peak_high_r <= '0;
      peak_low_r  <= MIN_NONE;
      last_r      <= '0;
      mean_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      enable_r    <= enable_nxt;
      slot_r      <= slot_nxt;
      held_r      <= held_nxt;
      sum_r       <= sum_nxt;
      peak_high_r <= peak_high_nxt;
      peak_low_r  <= peak_low_nxt;
      last_r      <= last_nxt;
      mean_r      <= mean_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `WAMA_ASSERT(a_held_bound, clk, rst_n, held_r <= CNT_W'(WINDOW))
  `WAMA_ASSERT_IMP(a_empty_sum, clk, rst_n, held_r == '0, sum_r == '0)
  `WAMA_ASSERT_NXT(a_xfer_busy, clk, rst_n, in_xfer, state_r != ST_IDLE)
  `WAMA_ASSERT_IMP(a_div_only_wait, clk, rst_n, div_stat.busy, state_r == ST_DIV)
  `WAMA_ASSERT_IMP(a_none_seen, clk, rst_n, peak_low_r == MIN_NONE,
                   (peak_high_r == '0) && (held_r == '0))

endmodule
